/* rtl/owtr_pkg.sv */
// Shared types, constants and helper functions for the 1-Wire temperature reader.
package owtr_pkg;

  // Width of the bus timing counter.
  localparam int unsigned TickCountWidth = 20;
  localparam int unsigned ScratchBytes   = 9;

  localparam logic [TickCountWidth-1:0] CntMax = '1;

  localparam int unsigned ReleaseTimeout = 300;
  localparam int unsigned SlotWriteLast  = 61;
  localparam int unsigned SlotReadLast   = 68;
  localparam int unsigned ReadSampleAt   = 9;
  localparam int unsigned WriteOneLow    = 2;
  localparam int unsigned WriteZeroLow   = 60;
  localparam int unsigned ReadLow        = 2;
  localparam int unsigned CmdBits        = 16;
  localparam int unsigned CrcBits        = (ScratchBytes - 1) * 8;

  localparam logic [7:0] CmdSkip    = 8'hCC;
  localparam logic [7:0] CmdConvert = 8'h44;
  localparam logic [7:0] CmdRead    = 8'hBE;
  localparam logic [7:0] CrcPoly    = 8'h8C;

  // Configuration register indexes.
  localparam logic [1:0] RegConvWait   = 2'd0;
  localparam logic [1:0] RegResetLow   = 2'd1;
  localparam logic [1:0] RegPresenceTo = 2'd2;

  // Result status codes.
  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusNoPresence = 2'd1;
  localparam logic [1:0] StatusNoRelease  = 2'd2;
  localparam logic [1:0] StatusCrcBad     = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_RST_A = 4'd1,
    PH_PW_A  = 4'd2,
    PH_PR_A  = 4'd3,
    PH_WR_A  = 4'd4,
    PH_CONV  = 4'd5,
    PH_RST_B = 4'd6,
    PH_PW_B  = 4'd7,
    PH_PR_B  = 4'd8,
    PH_WR_B  = 4'd9,
    PH_READ  = 4'd10
  } phase_t;

  typedef struct packed {
    logic [19:0] conv_wait;
    logic [9:0]  reset_low;
    logic [8:0]  presence_to;
  } cfg_t;

  typedef struct packed {
    logic        negative;
    logic [11:0] whole;
    logic [6:0]  hundredths;
  } temp_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    temp_t       temp;
  } result_t;

  // One bit of the reflected Maxim CRC-8.
  function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic din);
    logic [7:0] shifted;
    shifted = {1'b0, crc[7:1]};
    crc8_bit = (crc[0] ^ din) ? (shifted ^ CrcPoly) : shifted;
  endfunction

endpackage

/* rtl/owtr_convert.sv */
// Raw two's-complement 1/16 degree reading to sign, whole degrees and hundredths.
module owtr_convert (
  input  logic [15:0]   raw,
  output owtr_pkg::temp_t temp
);

  logic [15:0] mag;
  logic [10:0] frac_scaled;

  always_comb begin
    mag = raw[15] ? (16'd0 - raw) : raw;
    // Fraction nibble times 100, then drop four bits.
    frac_scaled = 11'({7'd0, mag[3:0]} * 11'd100);
    temp.negative   = raw[15];
    temp.whole      = mag[15:4];
    temp.hundredths = frac_scaled[10:4];
  end

endmodule

/* rtl/owtr_seq.sv */
// Bus sequencer: phase, slot timing, command shift-out, scratchpad read and CRC.
module owtr_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               command,
  input  logic               line_level,
  input  owtr_pkg::cfg_t     cfg,
  output owtr_pkg::result_t  result
);

  localparam int unsigned Tcw = owtr_pkg::TickCountWidth;

  owtr_pkg::phase_t phase, phase_next;
  logic [Tcw-1:0]   tick_count, tick_count_next;
  logic [6:0]       bit_index, bit_index_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [15:0]      raw_temperature, raw_temperature_next;
  logic [7:0]       crc_accumulator, crc_accumulator_next;
  logic [1:0]       last_status, last_status_next;
  owtr_pkg::temp_t  last_temperature, last_temperature_next;
  owtr_pkg::temp_t  conv_temp;

  logic             drive;
  logic             done;

  owtr_convert u_convert (
    .raw  (raw_temperature),
    .temp (conv_temp)
  );

  always_comb begin
    logic [Tcw-1:0] tc_inc;
    logic [31:0]    limit;
    logic [7:0]     wr_byte;
    logic           wr_bit;
    logic [6:0]     bi_inc;
    logic           fin;
    logic [1:0]     fin_status;

    phase_next            = phase;
    tick_count_next       = tick_count;
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    raw_temperature_next  = raw_temperature;
    crc_accumulator_next  = crc_accumulator;
    drive                 = 1'b0;
    fin                   = 1'b0;
    fin_status            = owtr_pkg::StatusOk;
    wr_byte               = owtr_pkg::CmdSkip;
    wr_bit                = 1'b0;
    bi_inc                = bit_index + 7'd1;
    limit                 = 32'(cfg.conv_wait);

    // Start only from idle; the first reset tick follows in the same transfer.
    if (phase == owtr_pkg::PH_IDLE && command) begin
      phase_next           = owtr_pkg::PH_RST_A;
      tick_count_next      = '0;
      bit_index_next       = '0;
      shift_byte_next      = '0;
      crc_accumulator_next = '0;
      raw_temperature_next = '0;
    end

    tc_inc = (tick_count_next < owtr_pkg::CntMax) ? tick_count_next + 1'b1 : tick_count_next;
    if (limit > 32'(owtr_pkg::CntMax)) begin
      limit = 32'(owtr_pkg::CntMax);
    end

    unique case (phase_next)
      owtr_pkg::PH_IDLE: begin
      end
      owtr_pkg::PH_RST_A, owtr_pkg::PH_RST_B: begin
        drive = 1'b1;
        tick_count_next = tc_inc;
        if (32'(tc_inc) >= 32'(cfg.reset_low)) begin
          phase_next      = owtr_pkg::phase_t'(phase_next + 4'd1);
          tick_count_next = '0;
        end
      end
      owtr_pkg::PH_PW_A, owtr_pkg::PH_PW_B: begin
        if (!line_level) begin
          phase_next      = owtr_pkg::phase_t'(phase_next + 4'd1);
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc;
          if (32'(tc_inc) >= 32'(cfg.presence_to)) begin
            fin        = 1'b1;
            fin_status = owtr_pkg::StatusNoPresence;
          end
        end
      end
      owtr_pkg::PH_PR_A, owtr_pkg::PH_PR_B: begin
        if (line_level) begin
          phase_next      = owtr_pkg::phase_t'(phase_next + 4'd1);
          tick_count_next = '0;
          bit_index_next  = '0;
        end else begin
          tick_count_next = tc_inc;
          if (32'(tc_inc) >= owtr_pkg::ReleaseTimeout) begin
            fin        = 1'b1;
            fin_status = owtr_pkg::StatusNoRelease;
          end
        end
      end
      owtr_pkg::PH_WR_A, owtr_pkg::PH_WR_B: begin
        if (bit_index_next < 7'd8) begin
          wr_byte = owtr_pkg::CmdSkip;
        end else if (phase_next == owtr_pkg::PH_WR_A) begin
          wr_byte = owtr_pkg::CmdConvert;
        end else begin
          wr_byte = owtr_pkg::CmdRead;
        end
        wr_bit = wr_byte[bit_index_next[2:0]];
        drive  = 32'(tick_count_next) <
                 (wr_bit ? owtr_pkg::WriteOneLow : owtr_pkg::WriteZeroLow);
        if (32'(tick_count_next) >= owtr_pkg::SlotWriteLast) begin
          tick_count_next = '0;
          bit_index_next  = bit_index_next + 7'd1;
          if (32'(bit_index_next) >= owtr_pkg::CmdBits) begin
            bit_index_next       = '0;
            shift_byte_next      = '0;
            crc_accumulator_next = '0;
            phase_next = (phase_next == owtr_pkg::PH_WR_A) ? owtr_pkg::PH_CONV
                                                            : owtr_pkg::PH_READ;
          end
        end else begin
          tick_count_next = tc_inc;
        end
      end
      owtr_pkg::PH_CONV: begin
        tick_count_next = tc_inc;
        if (32'(tc_inc) >= limit) begin
          phase_next      = owtr_pkg::PH_RST_B;
          tick_count_next = '0;
        end
      end
      owtr_pkg::PH_READ: begin
        drive = 32'(tick_count_next) < owtr_pkg::ReadLow;
        if (32'(tick_count_next) == owtr_pkg::ReadSampleAt) begin
          if (32'(bit_index_next) < owtr_pkg::CrcBits) begin
            crc_accumulator_next = owtr_pkg::crc8_bit(crc_accumulator_next, line_level);
          end
          shift_byte_next = {line_level, shift_byte_next[7:1]};
        end
        if (32'(tick_count_next) >= owtr_pkg::SlotReadLast) begin
          tick_count_next = '0;
          bi_inc          = bit_index_next + 7'd1;
          if (bit_index_next[2:0] == 3'd7) begin
            if (bit_index_next[6:3] == 4'd0) begin
              raw_temperature_next[7:0] = shift_byte_next;
            end else if (bit_index_next[6:3] == 4'd1) begin
              raw_temperature_next[15:8] = shift_byte_next;
            end
          end
          // Last byte is the CRC: compare and end the transaction.
          if (bit_index_next[2:0] == 3'd7 &&
              32'(bit_index_next[6:3]) >= owtr_pkg::ScratchBytes - 1) begin
            fin        = 1'b1;
            fin_status = (crc_accumulator_next == shift_byte_next) ? owtr_pkg::StatusOk
                                                                   : owtr_pkg::StatusCrcBad;
          end else begin
            bit_index_next = bi_inc;
          end
        end else begin
          tick_count_next = tc_inc;
        end
      end
      default: begin
        phase_next      = owtr_pkg::PH_IDLE;
        tick_count_next = '0;
        bit_index_next  = '0;
      end
    endcase

    done                  = fin;
    last_status_next      = last_status;
    last_temperature_next = last_temperature;
    if (fin) begin
      last_status_next = fin_status;
      if (fin_status == owtr_pkg::StatusOk) begin
        last_temperature_next = conv_temp;
      end
      phase_next      = owtr_pkg::PH_IDLE;
      tick_count_next = '0;
      bit_index_next  = '0;
    end
  end

  always_comb begin
    result.drive_low = drive;
    result.busy_res  = (phase_next != owtr_pkg::PH_IDLE);
    result.done_res  = done;
    result.status    = last_status_next;
    result.temp      = last_temperature_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= owtr_pkg::PH_IDLE;
      tick_count       <= '0;
      bit_index        <= '0;
      shift_byte       <= '0;
      raw_temperature  <= '0;
      crc_accumulator  <= '0;
      last_status      <= owtr_pkg::StatusOk;
      last_temperature <= '0;
    end else if (fire) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      bit_index        <= bit_index_next;
      shift_byte       <= shift_byte_next;
      raw_temperature  <= raw_temperature_next;
      crc_accumulator  <= crc_accumulator_next;
      last_status      <= last_status_next;
      last_temperature <= last_temperature_next;
    end
  end

endmodule

/* rtl/onewire_temperature_reader_unit.sv */
// Top level of the 1-Wire temperature reader: handshakes, configuration and result register.
//
// Usage:
//   Tick channel (tick_valid / tick_stall, payload command, line_level): one
//   transfer per bus microsecond. line_level is the sampled bus level; a
//   command of 1 while idle starts the full read sequence (reset, presence,
//   skip-ROM + convert, conversion wait, second reset, skip-ROM + read
//   scratchpad, nine bytes with Maxim CRC-8 check).
//   Result channel (res_valid / res_stall): exactly one result per tick
//   transfer, carrying drive_low for the open-drain driver, busy/done flags,
//   the last status and the last good temperature.
//   The result of a tick shows in the result register on the cycle after its
//   transfer. One tick is taken per cycle while the result channel does not
//   stall; the sequencer updates its state in the same cycle the tick is taken.
//   When the receiver stalls, the result register holds and tick_stall rises
//   so no new tick is taken until the waiting result is moved on; when the
//   result is taken in the same cycle, the next tick is accepted at once.
//   Configuration (cfg_we, cfg_index, cfg_data) writes conversion wait,
//   reset-pulse length and presence timeout; write only while idle.
//   Reset (rst, synchronous) returns the sequencer to idle, clears status and
//   temperature, empties the result register and restores register defaults.
module onewire_temperature_reader_unit (
  input  logic        clk,
  input  logic        rst,
  // tick channel
  input  logic        tick_valid,
  output logic        tick_stall,
  input  logic        command,
  input  logic        line_level,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic        drive_low,
  output logic        busy_res,
  output logic        done_res,
  output logic [1:0]  status,
  output logic        temp_negative,
  output logic [11:0] temp_integer,
  output logic [6:0]  temp_hundredths,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  owtr_pkg::cfg_t    cfg;
  owtr_pkg::result_t seq_result;
  owtr_pkg::result_t res;
  logic              fire;

  // Take a tick unless a finished result is still waiting downstream.
  assign tick_stall = res_valid && res_stall;
  assign fire       = tick_valid && !tick_stall;

  // Configuration registers; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conv_wait   <= 20'd1000000;
      cfg.reset_low   <= 10'd480;
      cfg.presence_to <= 9'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        owtr_pkg::RegConvWait:   cfg.conv_wait   <= cfg_data;
        owtr_pkg::RegResetLow:   cfg.reset_low   <= cfg_data[9:0];
        owtr_pkg::RegPresenceTo: cfg.presence_to <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  owtr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .command    (command),
    .line_level (line_level),
    .cfg        (cfg),
    .result     (seq_result)
  );

  // Result register: load on every tick transfer, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= seq_result;
    end
  end

  assign drive_low       = res.drive_low;
  assign busy_res        = res.busy_res;
  assign done_res        = res.done_res;
  assign status          = res.status;
  assign temp_negative   = res.temp.negative;
  assign temp_integer    = res.temp.whole;
  assign temp_hundredths = res.temp.hundredths;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the 1-Wire temperature reader unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Bus timing as the sequencer sees it, in ticks.
  localparam int unsigned OneLowTicks    = 2;
  localparam int unsigned ZeroLowTicks   = 60;
  localparam int unsigned ReadLowTicks   = 2;
  localparam int unsigned WriteSlotEnd   = 61;
  localparam int unsigned ReadSlotEnd    = 68;
  localparam int unsigned ReadSampleTick = 9;
  localparam int unsigned ReleaseLimit   = 300;
  localparam int unsigned CommandBits    = 16;
  localparam int unsigned CrcBytes       = 8;

  localparam logic [7:0] SkipRom     = 8'hCC;
  localparam logic [7:0] ConvertT    = 8'h44;
  localparam logic [7:0] ReadScratch = 8'hBE;
  localparam logic [7:0] MaximPoly   = 8'h8C;

  // Hard stop, far beyond the slowest legal run.
  localparam int unsigned RunLimitNs = 100_000_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        tick_valid = 1'b0;
  logic        tick_stall;
  logic        command = 1'b0;
  logic        line_level = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  status;
  logic        temp_negative;
  logic [11:0] temp_integer;
  logic [6:0]  temp_hundredths;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = owtr_pkg::RegConvWait;
  logic [19:0] cfg_data = '0;

  // Predicted sequencer state, with the timing registers at their reset values.
  owtr_pkg::cfg_t   timing = {20'd1000000, 10'd480, 9'd100};
  owtr_pkg::phase_t rd_phase = owtr_pkg::PH_IDLE;
  logic [19:0]      rd_ticks = '0;
  logic [6:0]       rd_bit = '0;
  logic [7:0]       rd_shift = '0;
  logic [15:0]      rd_raw = '0;
  logic [7:0]       rd_crc = '0;
  logic [1:0]       rd_status = owtr_pkg::StatusOk;
  owtr_pkg::temp_t  rd_temp = '0;
  logic             rd_done = 1'b0;

  // What the simulated slave answers during the current reading.
  int unsigned presence_delay [2];
  int unsigned presence_hold [2];
  logic [7:0]  scratchpad [9];

  owtr_pkg::result_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned sender_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  onewire_temperature_reader_unit dut (
    .clk             (clk),
    .rst             (rst),
    .tick_valid      (tick_valid),
    .tick_stall      (tick_stall),
    .command         (command),
    .line_level      (line_level),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .drive_low       (drive_low),
    .busy_res        (busy_res),
    .done_res        (done_res),
    .status          (status),
    .temp_negative   (temp_negative),
    .temp_integer    (temp_integer),
    .temp_hundredths (temp_hundredths),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One bit of the reflected CRC-8: shift right, fold in the polynomial on a one.
  function automatic logic [7:0] crc_shift(input logic [7:0] crc, input logic din);
    crc_shift = (crc >> 1) ^ ((crc[0] ^ din) ? MaximPoly : 8'h00);
  endfunction

  // Turn a raw 1/16 degree reading into sign, whole degrees and hundredths.
  function automatic owtr_pkg::temp_t decode_celsius(input logic [15:0] raw);
    owtr_pkg::temp_t t;
    logic [15:0]     mag;
    // Negate over the full 16 bits so that 0x8000 gives 2048 degrees.
    mag          = raw[15] ? (~raw + 16'd1) : raw;
    t.negative   = raw[15];
    t.whole      = mag[15:4];
    t.hundredths = 7'((32'(mag[3:0]) * 100) >> 4);
    return t;
  endfunction

  // Advance the tick counter, saturating at its top value.
  task automatic bump_ticks();
    if (rd_ticks != '1) rd_ticks = rd_ticks + 20'd1;
  endtask

  // Close the running reading; only a good one replaces the held temperature.
  task automatic end_reading(input logic [1:0] code);
    rd_status = code;
    if (code == owtr_pkg::StatusOk) rd_temp = decode_celsius(rd_raw);
    rd_phase = owtr_pkg::PH_IDLE;
    rd_ticks = '0;
    rd_bit   = '0;
    rd_done  = 1'b1;
  endtask

  // Apply one tick to the predicted sequencer and queue the result it must give.
  task automatic step_reader(input logic cmd, input logic lvl);
    owtr_pkg::result_t r;
    logic [7:0]        cmd_byte;
    logic              slot_bit;
    logic              drv;
    drv     = 1'b0;
    rd_done = 1'b0;
    // A start is honored only from idle; while busy it is just a tick.
    if (rd_phase == owtr_pkg::PH_IDLE && cmd) begin
      rd_phase = owtr_pkg::PH_RST_A;
      rd_ticks = '0;
      rd_bit   = '0;
      rd_shift = '0;
      rd_crc   = '0;
      rd_raw   = '0;
    end
    case (rd_phase)
      owtr_pkg::PH_IDLE: begin
      end
      owtr_pkg::PH_RST_A, owtr_pkg::PH_RST_B: begin
        // Hold the bus low; at least one tick even with a zero length.
        drv = 1'b1;
        bump_ticks();
        if (rd_ticks >= timing.reset_low) begin
          if (rd_phase == owtr_pkg::PH_RST_A) rd_phase = owtr_pkg::PH_PW_A;
          else rd_phase = owtr_pkg::PH_PW_B;
          rd_ticks = '0;
        end
      end
      owtr_pkg::PH_PW_A, owtr_pkg::PH_PW_B: begin
        if (!lvl) begin
          if (rd_phase == owtr_pkg::PH_PW_A) rd_phase = owtr_pkg::PH_PR_A;
          else rd_phase = owtr_pkg::PH_PR_B;
          rd_ticks = '0;
        end else begin
          bump_ticks();
          if (rd_ticks >= timing.presence_to) end_reading(owtr_pkg::StatusNoPresence);
        end
      end
      owtr_pkg::PH_PR_A, owtr_pkg::PH_PR_B: begin
        if (lvl) begin
          if (rd_phase == owtr_pkg::PH_PR_A) rd_phase = owtr_pkg::PH_WR_A;
          else rd_phase = owtr_pkg::PH_WR_B;
          rd_ticks = '0;
          rd_bit   = '0;
        end else begin
          bump_ticks();
          if (rd_ticks >= ReleaseLimit) end_reading(owtr_pkg::StatusNoRelease);
        end
      end
      owtr_pkg::PH_WR_A, owtr_pkg::PH_WR_B: begin
        // Skip-ROM first, then convert or read-scratchpad, LSB first.
        if (rd_bit < 8) cmd_byte = SkipRom;
        else if (rd_phase == owtr_pkg::PH_WR_A) cmd_byte = ConvertT;
        else cmd_byte = ReadScratch;
        slot_bit = cmd_byte[rd_bit[2:0]];
        drv      = (rd_ticks < (slot_bit ? OneLowTicks : ZeroLowTicks));
        if (rd_ticks >= WriteSlotEnd) begin
          rd_ticks = '0;
          rd_bit   = rd_bit + 7'd1;
          if (rd_bit >= CommandBits) begin
            rd_bit   = '0;
            rd_shift = '0;
            rd_crc   = '0;
            if (rd_phase == owtr_pkg::PH_WR_A) rd_phase = owtr_pkg::PH_CONV;
            else rd_phase = owtr_pkg::PH_READ;
          end
        end else begin
          bump_ticks();
        end
      end
      owtr_pkg::PH_CONV: begin
        bump_ticks();
        if (rd_ticks >= timing.conv_wait) begin
          rd_phase = owtr_pkg::PH_RST_B;
          rd_ticks = '0;
        end
      end
      owtr_pkg::PH_READ: begin
        drv = (rd_ticks < ReadLowTicks);
        if (rd_ticks == ReadSampleTick) begin
          // The CRC covers every byte but the last one.
          if (rd_bit < CrcBytes * 8) rd_crc = crc_shift(rd_crc, lvl);
          rd_shift = {lvl, rd_shift[7:1]};
        end
        if (rd_ticks >= ReadSlotEnd) begin
          rd_ticks = '0;
          if (rd_bit[2:0] == 3'd7 && rd_bit[6:3] == 4'd0) rd_raw[7:0] = rd_shift;
          if (rd_bit[2:0] == 3'd7 && rd_bit[6:3] == 4'd1) rd_raw[15:8] = rd_shift;
          if (rd_bit[2:0] == 3'd7 && rd_bit[6:3] >= CrcBytes)
            end_reading((rd_crc == rd_shift) ? owtr_pkg::StatusOk : owtr_pkg::StatusCrcBad);
          else
            rd_bit = rd_bit + 7'd1;
        end else begin
          bump_ticks();
        end
      end
      default: begin
        rd_phase = owtr_pkg::PH_IDLE;
        rd_ticks = '0;
        rd_bit   = '0;
      end
    endcase
    r.drive_low = drv;
    r.busy_res  = (rd_phase != owtr_pkg::PH_IDLE);
    r.done_res  = rd_done;
    r.status    = rd_status;
    r.temp      = rd_temp;
    pending_results.push_back(r);
  endtask

  // Level the simulated slave puts on the bus for the next tick, from the
  // predicted state. Outside presence and the read sample the level is noise.
  function automatic logic bus_level();
    case (rd_phase)
      owtr_pkg::PH_PW_A: return (rd_ticks >= presence_delay[0]) ? 1'b0 : 1'b1;
      owtr_pkg::PH_PW_B: return (rd_ticks >= presence_delay[1]) ? 1'b0 : 1'b1;
      owtr_pkg::PH_PR_A: return (rd_ticks >= presence_hold[0]) ? 1'b1 : 1'b0;
      owtr_pkg::PH_PR_B: return (rd_ticks >= presence_hold[1]) ? 1'b1 : 1'b0;
      owtr_pkg::PH_READ: begin
        if (rd_ticks == ReadSampleTick) return scratchpad[rd_bit[6:3]][rd_bit[2:0]];
      end
      default: begin
      end
    endcase
    return 1'($urandom_range(1));
  endfunction

  // Offer one tick, with random gaps ahead of it, and hold it until the
  // transfer; then predict its result.
  task automatic send_tick(input logic cmd, input logic lvl);
    while ($urandom_range(99) < sender_gap_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    command    <= cmd;
    line_level <= lvl;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    step_reader(cmd, lvl);
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic drain_results();
    tick_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Let the result register settle.
    repeat (2) @(posedge clk);
  endtask

  // Write all three timing registers; junk in the unused upper data bits.
  task automatic program_timing(input logic [19:0] conv, input logic [9:0] low,
                                input logic [8:0] pres);
    cfg_we    <= 1'b1;
    cfg_index <= owtr_pkg::RegConvWait;
    cfg_data  <= conv;
    @(posedge clk);
    cfg_index <= owtr_pkg::RegResetLow;
    cfg_data  <= {10'($urandom), low};
    @(posedge clk);
    cfg_index <= owtr_pkg::RegPresenceTo;
    cfg_data  <= {11'($urandom), pres};
    @(posedge clk);
    cfg_we <= 1'b0;
    timing.conv_wait   = conv;
    timing.reset_low   = low;
    timing.presence_to = pres;
  endtask

  // Run one start-to-done transaction against the slave model. The slave
  // answers presence after wait_* high samples, holds it for hold_* low
  // samples and returns a scratchpad built around raw; crc_flip spoils the
  // CRC byte when nonzero.
  task automatic run_reading(input logic [15:0] raw, input logic [7:0] crc_flip,
                             input int unsigned wait_a, input int unsigned hold_a,
                             input int unsigned wait_b, input int unsigned hold_b);
    logic [7:0] crc;
    presence_delay[0] = wait_a;
    presence_hold[0]  = hold_a;
    presence_delay[1] = wait_b;
    presence_hold[1]  = hold_b;
    scratchpad[0] = raw[7:0];
    scratchpad[1] = raw[15:8];
    for (int i = 2; i < CrcBytes; i++) scratchpad[i] = 8'($urandom);
    crc = '0;
    for (int i = 0; i < CrcBytes * 8; i++) crc = crc_shift(crc, scratchpad[i / 8][i % 8]);
    scratchpad[8] = crc ^ crc_flip;
    send_tick(1'b1, bus_level());
    // Random starts while busy must be ignored.
    while (rd_phase != owtr_pkg::PH_IDLE) begin
      if ($urandom_range(2999) == 0) drain_results();
      send_tick(1'($urandom_range(1)), bus_level());
    end
  endtask

  // Plain ticks out of reset: bus released, nothing reported.
  task automatic test_idle_ticks();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    drain_results();
  endtask

  // Presence timeouts and release timeout at the register extremes, then a
  // full reading with the longest reset pulse and a zero conversion wait.
  task automatic test_presence_limits();
    program_timing(20'hFFFFF, 10'd0, 9'd0);
    run_reading(16'h0550, 8'h00, 1, 0, 0, 0);
    run_reading(16'h0550, 8'h00, 0, ReleaseLimit, 0, 0);
    drain_results();
    program_timing(20'd0, 10'd1023, 9'd511);
    run_reading(16'h0550, 8'h00, 511, 0, 0, 0);
    run_reading(16'h7FFF, 8'h00, 510, ReleaseLimit - 1, 0, 0);
    drain_results();
  endtask

  // Most negative reading and one just below the presence limits.
  task automatic test_negative_readings();
    program_timing(20'd37, 10'd8, 9'd40);
    run_reading(16'h8000, 8'h00, 3, 12, 0, 5);
    run_reading(16'hFE6F, 8'h00, 0, 0, 39, ReleaseLimit - 1);
    drain_results();
  endtask

  // Bad CRC: status flags it and the last good temperature stays.
  task automatic test_crc_mismatch();
    run_reading(16'h0191, 8'h5A, 2, 7, 1, 3);
    drain_results();
  endtask

  // Mostly well-formed readings with random content, sprinkled with presence
  // failures, stuck releases and spoiled CRCs; timing reprogrammed now and then.
  task automatic test_random_readings(input int unsigned readings);
    int unsigned pres_to;
    int unsigned roll;
    int unsigned wait_a, hold_a, wait_b, hold_b;
    logic [15:0] raw;
    logic [7:0]  flip;
    pres_to = 1;
    for (int n = 0; n < readings; n++) begin
      if (n % 3 == 0) begin
        drain_results();
        pres_to = $urandom_range(150, 1);
        program_timing(20'($urandom_range(60)), 10'($urandom_range(90)), 9'(pres_to));
      end
      repeat ($urandom_range(12)) send_tick(1'b0, 1'($urandom_range(1)));
      wait_a = $urandom_range(pres_to - 1);
      wait_b = $urandom_range(pres_to - 1);
      hold_a = $urandom_range(40);
      hold_b = $urandom_range(40);
      roll   = $urandom_range(99);
      if (roll < 8) wait_a = pres_to + $urandom_range(3);
      else if (roll < 14) wait_b = pres_to + $urandom_range(3);
      else if (roll < 19) hold_a = ReleaseLimit + $urandom_range(4);
      else if (roll < 23) hold_b = ReleaseLimit + $urandom_range(4);
      raw = 16'($urandom);
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(3))
          0: raw = 16'h8000;
          1: raw = 16'h7FFF;
          2: raw = 16'hFFFF;
          default: raw = 16'h0000;
        endcase
      end
      flip = ($urandom_range(99) < 12) ? 8'($urandom_range(255, 1)) : 8'h00;
      run_reading(raw, flip, wait_a, hold_a, wait_b, hold_b);
    end
    drain_results();
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      if (mismatches < 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
      mismatches++;
    end
  endtask

  // Take each result transfer, check it against the oldest prediction, and
  // pick the stall for the next cycle.
  always @(posedge clk) begin : check_results
    owtr_pkg::result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("result %0d: no result was expected", results_seen);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("drive_low", want.drive_low, drive_low);
        compare_field("busy_res", want.busy_res, busy_res);
        compare_field("done_res", want.done_res, done_res);
        compare_field("status", want.status, status);
        compare_field("temp_negative", want.temp.negative, temp_negative);
        compare_field("temp_integer", want.temp.whole, temp_integer);
        compare_field("temp_hundredths", want.temp.hundredths, temp_hundredths);
      end
      results_seen++;
    end
    res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    // Sparse sender gaps against a mostly stalled receiver first.
    sender_gap_pct = 7;
    recv_stall_pct = 86;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_idle_ticks();
    test_presence_limits();
    test_negative_readings();
    test_crc_mismatch();
    test_random_readings(5);
    // Swap: a slow sender against a mostly ready receiver.
    sender_gap_pct = 86;
    recv_stall_pct = 7;
    test_random_readings(5);
    // Full rate on both sides.
    sender_gap_pct = 0;
    recv_stall_pct = 0;
    test_random_readings(12);
    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Catch a hung handshake.
  initial begin
    #(RunLimitNs);
    $display("testbench: FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/owtr_pkg.sv
rtl/owtr_convert.sv
rtl/owtr_seq.sv
rtl/onewire_temperature_reader_unit.sv
tb/testbench.sv
